/* design/dcm_pkg.sv */
// Shared types and constants for the density colour-map pixel pipeline.
// Depends on nothing; imported by the normaliser, the map stage and the top level.
`default_nettype none

package dcm_pkg;

  // Fraction bits of the incoming density sample.
  localparam int FRAC_BITS = 8;
  localparam int DENS_W    = 24;
  localparam int LEVEL_W   = 17;  // Q1.16 level, 65536 means exactly one

  // Clamp ceiling, 255.0 in the sample's fixed-point format.
  localparam logic [DENS_W-1:0] DENS_TOP = DENS_W'(255 << FRAC_BITS);
  localparam int NORM_LSH = 16 - FRAC_BITS;

  // Reciprocal of 255, rounded up, scaled by two to the NORM_SHIFT.
  localparam int NORM_SHIFT = 32;
  localparam logic [63:0] NORM_MUL_64 = ((64'd1 << NORM_SHIFT) + 64'd254) / 64'd255;
  localparam logic [24:0] NORM_MUL = NORM_MUL_64[24:0];

  localparam logic [LEVEL_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [LEVEL_W-1:0] HALF_Q16 = 17'd32768;
  localparam logic [LEVEL_W-1:0] HEAT_T1  = 17'd21627;
  localparam logic [LEVEL_W-1:0] HEAT_T2  = 17'd43254;

  // 255 / segment width, rounded up, scaled by two to the SCALE_SHIFT.
  localparam int SCALE_SHIFT = 34;
  localparam logic [63:0] HEAT_LO_MUL_64 =
    ((64'd255 << SCALE_SHIFT) + 64'd21626) / 64'd21627;
  localparam logic [63:0] HEAT_HI_MUL_64 =
    ((64'd255 << SCALE_SHIFT) + 64'd22281) / 64'd22282;
  localparam logic [27:0] HEAT_LO_MUL = HEAT_LO_MUL_64[27:0];
  localparam logic [27:0] HEAT_HI_MUL = HEAT_HI_MUL_64[27:0];

  typedef enum logic [1:0] {
    MAP_HEAT     = 2'd0,
    MAP_COOLWARM = 2'd1,
    MAP_VIRIDIS  = 2'd2,
    MAP_RAINBOW  = 2'd3
  } color_map_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

/* design/dcm_norm.sv */
// Clamp of the density sample and normalisation to a Q1.16 level.
// Depends on dcm_pkg.
`default_nettype none

module dcm_norm (
  input  logic [dcm_pkg::DENS_W-1:0]  density_value,
  input  logic                        solid_cell,
  output logic [dcm_pkg::LEVEL_W-1:0] level
);
  import dcm_pkg::*;

  logic [DENS_W-1:0] dens_clamped;
  logic [DENS_W-1:0] dens_scaled;
  logic [48:0]       norm_prod;

  // Solid cells and negative samples read as zero density.
  always_comb begin
    if (solid_cell || density_value[DENS_W-1]) begin
      dens_clamped = '0;
    end else if (density_value > DENS_TOP) begin
      dens_clamped = DENS_TOP;
    end else begin
      dens_clamped = density_value;
    end
  end

  // The scaled value never exceeds 255 times 65536, so it fits in 24 bits,
  // and the rounded-up reciprocal gives the exact floor of it over 255.
  assign dens_scaled = dens_clamped << NORM_LSH;
  assign norm_prod   = 49'(dens_scaled) * 49'(NORM_MUL);
  assign level       = norm_prod[NORM_SHIFT+LEVEL_W-1:NORM_SHIFT];

endmodule

`default_nettype wire

/* design/dcm_map.sv */
// Colour map stage: turns a Q1.16 level into RGB for the selected map.
// Depends on dcm_pkg; the solid-cell inversion is applied here as well.
`default_nettype none

module dcm_map (
  input  dcm_pkg::color_map_t         map_sel,
  input  logic [dcm_pkg::LEVEL_W-1:0] level,
  input  logic                        solid_cell,
  output dcm_pkg::rgb_t               pixel
);
  import dcm_pkg::*;

  logic               heat_lo;
  logic               heat_mid;
  logic [LEVEL_W-1:0] heat_x;
  logic [27:0]        heat_mul;
  logic [44:0]        heat_prod;
  logic [7:0]         heat_ch;

  logic               cw_lo;
  logic [LEVEL_W-1:0] cw_x;
  logic [24:0]        cw_prod;
  logic [7:0]         cw_ch;

  logic [24:0]        vir_r_prod;
  logic [24:0]        vir_g_prod;
  logic [24:0]        vir_b_prod;

  logic [19:0]        hue;
  logic [3:0]         sextant;
  logic [LEVEL_W-1:0] hue_x;
  logic [24:0]        hue_prod;
  logic [7:0]         hue_ch;

  rgb_t heat_rgb, cw_rgb, vir_rgb, hue_rgb, map_rgb;

  // Heat: one shared multiplier, the segment picks its offset and slope.
  assign heat_lo   = level < HEAT_T1;
  assign heat_mid  = level < HEAT_T2;
  assign heat_x    = heat_lo ? level : (heat_mid ? level - HEAT_T1 : level - HEAT_T2);
  assign heat_mul  = (heat_lo || heat_mid) ? HEAT_LO_MUL : HEAT_HI_MUL;
  assign heat_prod = 45'(heat_x) * 45'(heat_mul);
  assign heat_ch   = heat_prod[SCALE_SHIFT+7:SCALE_SHIFT];

  always_comb begin
    if (heat_lo) begin
      heat_rgb = '{red: heat_ch, green: 8'd0, blue: 8'd0};
    end else if (heat_mid) begin
      heat_rgb = '{red: 8'd255, green: heat_ch, blue: 8'd0};
    end else begin
      heat_rgb = '{red: 8'd255, green: 8'd255, blue: heat_ch};
    end
  end

  // Cool-warm: blue to white to red about the midpoint.
  assign cw_lo   = level < HALF_Q16;
  assign cw_x    = cw_lo ? level : ONE_Q16 - level;
  assign cw_prod = 25'(cw_x) * 25'd255;
  assign cw_ch   = cw_prod[22:15];
  assign cw_rgb  = cw_lo ? '{red: cw_ch, green: cw_ch, blue: 8'd255}
                         : '{red: 8'd255, green: cw_ch, blue: cw_ch};

  // Viridis: three straight lines; blue rounds its decrement up.
  assign vir_r_prod = 25'(level) * 25'd185;
  assign vir_g_prod = 25'(level) * 25'd230;
  assign vir_b_prod = 25'(level) * 25'd47 + 25'd65535;
  assign vir_rgb = '{red:   8'd68 + vir_r_prod[23:16],
                     green: 8'd1  + vir_g_prod[23:16],
                     blue:  8'd84 - vir_b_prod[23:16]};

  // Rainbow: the hue is split into a sextant and a ramp within it.
  assign hue      = 20'(level) * 20'd6;
  assign sextant  = hue[19:16];
  assign hue_x    = sextant[0] ? ONE_Q16 - LEVEL_W'(hue[15:0]) : LEVEL_W'(hue[15:0]);
  assign hue_prod = 25'(hue_x) * 25'd255;
  assign hue_ch   = hue_prod[23:16];

  always_comb begin
    case (sextant)
      4'd0:    hue_rgb = '{red: 8'd255, green: hue_ch, blue: 8'd0};
      4'd1:    hue_rgb = '{red: hue_ch, green: 8'd255, blue: 8'd0};
      4'd2:    hue_rgb = '{red: 8'd0, green: 8'd255, blue: hue_ch};
      4'd3:    hue_rgb = '{red: 8'd0, green: hue_ch, blue: 8'd255};
      4'd4:    hue_rgb = '{red: hue_ch, green: 8'd0, blue: 8'd255};
      // Last sextant, and full-scale hue which falls in with it.
      default: hue_rgb = '{red: 8'd255, green: 8'd0, blue: hue_ch};
    endcase
  end

  always_comb begin
    case (map_sel)
      MAP_HEAT:     map_rgb = heat_rgb;
      MAP_COOLWARM: map_rgb = cw_rgb;
      MAP_VIRIDIS:  map_rgb = vir_rgb;
      MAP_RAINBOW:  map_rgb = hue_rgb;
      default:      map_rgb = heat_rgb;
    endcase
  end

  // 255 minus a channel is its bitwise complement.
  assign pixel = solid_cell ? ~map_rgb : map_rgb;

endmodule

`default_nettype wire

/* design/density_colormap_pixel.sv */
// Density colour-map pixel pipeline, top level.
// An accepted item moves through the input, level and result registers in turn.
// Throughput: one item per cycle while pixel_ready is high; each register holds
// an item and a stall only holds back the stages behind a full one.
// Reset clears every stage's valid flag and selects the heat map.
// Depends on dcm_pkg, dcm_norm and dcm_map.
`default_nettype none

module density_colormap_pixel (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration: colour map select, written whenever cfg_we is high.
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_wdata,
  // Density samples in.
  input  logic                              density_valid,
  output logic                              density_ready,
  input  logic signed [dcm_pkg::DENS_W-1:0] density_value,
  input  logic                              solid_cell,
  // Pixels out.
  output logic                              pixel_valid,
  input  logic                              pixel_ready,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue
);
  import dcm_pkg::*;

  color_map_t          color_map;

  // Stage one: the accepted item as it arrived.
  logic                s1_valid;
  logic [DENS_W-1:0]   s1_density;
  logic                s1_solid;

  // Stage two: the normalised level.
  logic                s2_valid;
  logic [LEVEL_W-1:0]  s2_level;
  logic                s2_solid;

  logic                out_free;
  logic                s2_free;
  logic                s1_free;
  logic [LEVEL_W-1:0]  level_next;
  rgb_t                pixel_next;

  // A stage may take a new item when it is empty or its item moves on in
  // the same cycle, so bubbles close up and a full pipe still streams.
  assign out_free      = !pixel_valid || pixel_ready;
  assign s2_free       = !s2_valid || out_free;
  assign s1_free       = !s1_valid || s2_free;
  assign density_ready = s1_free;

  dcm_norm u_norm (
    .density_value (s1_density),
    .solid_cell    (s1_solid),
    .level         (level_next)
  );

  dcm_map u_map (
    .map_sel    (color_map),
    .level      (s2_level),
    .solid_cell (s2_solid),
    .pixel      (pixel_next)
  );

  // Control state: the map select and the stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_map   <= MAP_HEAT;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        color_map <= color_map_t'(cfg_wdata);
      end
      if (s1_free) begin
        s1_valid <= density_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        pixel_valid <= s2_valid;
      end
    end
  end

  // Payload registers load only when their stage takes an item.
  always_ff @(posedge clk) begin
    if (s1_free && density_valid) begin
      s1_density <= density_value;
      s1_solid   <= solid_cell;
    end
    if (s2_free && s1_valid) begin
      s2_level <= level_next;
      s2_solid <= s1_solid;
    end
    if (out_free && s2_valid) begin
      red   <= pixel_next.red;
      green <= pixel_next.green;
      blue  <= pixel_next.blue;
    end
  end

  // The normalised level never passes exactly one.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> s2_level <= ONE_Q16)
    else $error("normalised level above one");

  // With the result register empty nothing can hold the input back.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !pixel_valid |-> density_ready)
    else $error("input stalled with an empty result register");

  // An accepted item lands in the input stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    density_valid && density_ready |=> s1_valid)
    else $error("accepted item lost at the input stage");

  // An item leaving the level stage becomes a result.
  a_level_moves: assert property (@(posedge clk) disable iff (rst)
    s2_valid && out_free |=> pixel_valid)
    else $error("item lost between level stage and result register");

endmodule

`default_nettype wire
